// File: hdl/assert_macros.svh
// Assertion macros used by the checking file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/lcs_pkg.sv
// Package: types, codes and constants of the LCS table and traceback block.
package lcs_pkg;

    // Default and field widths
    localparam int MAX_LEN_DEF = 32;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 6;

    // Front queue depth
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // Command codes on the input channel
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    // Direction codes kept per cell
    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;
    localparam logic [1:0] DIR_LEFT = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SYM_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             symbol_valid;
        logic [LEN_W-1:0] lcs_length;
        logic             last;
    } out_item_t;

    // Classified operation handed from front to engine
    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_RUN
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [SYM_W-1:0] symbol;
    } q_entry_t;

    typedef struct packed {
        logic             valid;
        op_kind_t         kind;
        logic [SYM_W-1:0] symbol;
    } fe_to_be_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL_RD,
        ST_CELL,
        ST_TB_RD,
        ST_TB,
        ST_EMIT_SET,
        ST_EMPTY,
        ST_EM_RD,
        ST_EM
    } eng_state_t;

endpackage

// File: hdl/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/lcs_front.sv
// Front end: accepts input transfers, classifies commands, short queue to the engine.
module lcs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lcs_pkg::in_item_t  item,
    input  logic               take,
    output lcs_pkg::fe_to_be_t fe
);

    lcs_pkg::q_entry_t              entry_reg [lcs_pkg::FQ_DEPTH];
    logic [lcs_pkg::FQ_PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lcs_pkg::FQ_PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lcs_pkg::FQ_CW-1:0]      count_reg, count_next;
    logic                           enq;
    logic                           deq;
    lcs_pkg::q_entry_t              new_entry;

    localparam logic [lcs_pkg::FQ_CW-1:0] FULL_CNT = lcs_pkg::FQ_CW'(lcs_pkg::FQ_DEPTH);
    localparam logic [lcs_pkg::FQ_PW-1:0] LAST_PTR = lcs_pkg::FQ_PW'(lcs_pkg::FQ_DEPTH - 1);

    assign full = (count_reg == FULL_CNT);

    // Classify: the unused command is taken and dropped here
    always_comb
    begin
        new_entry.symbol = item.symbol;
        new_entry.kind   = lcs_pkg::OP_RUN;
        enq              = push && !full;
        case (item.cmd)
            lcs_pkg::CMD_LOAD_A: new_entry.kind = lcs_pkg::OP_LOAD_A;
            lcs_pkg::CMD_LOAD_B: new_entry.kind = lcs_pkg::OP_LOAD_B;
            lcs_pkg::CMD_RUN:    new_entry.kind = lcs_pkg::OP_RUN;
            default:             enq            = 1'b0;
        endcase
    end

    assign deq = take && (count_reg != '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign fe.valid  = (count_reg != '0);
    assign fe.kind   = entry_reg[rd_ptr_reg].kind;
    assign fe.symbol = entry_reg[rd_ptr_reg].symbol;

endmodule

// File: hdl/lcs_engine.sv
// Engine: sequence stores, score recurrence, traceback and result output register.
module lcs_engine #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lcs_pkg::fe_to_be_t fe,
    output logic               take,
    output logic               empty,
    input  logic               pop,
    output lcs_pkg::out_item_t result
);

    localparam int AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int DIR_DEPTH = MAX_LEN << AW;
    localparam int DIR_AW    = $clog2(DIR_DEPTH);
    localparam int OUT_LW    = lcs_pkg::LEN_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    lcs_pkg::eng_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_a_reg, count_a_next;
    logic [CNT_W-1:0] count_b_reg, count_b_next;
    logic [CNT_W-1:0] m_reg, m_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] diag_reg, diag_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             out_valid_reg, out_valid_next;
    lcs_pkg::out_item_t out_item_reg, out_item_next;

    logic [CNT_W-1:0] im1, jm1, rev_idx;
    logic             out_free;

    // RAM port signals
    logic                       sa_we, sa_re, sb_we, sb_re;
    logic [AW-1:0]              sa_waddr, sa_raddr, sb_waddr;
    logic [lcs_pkg::SYM_W-1:0]  sa_rdata, sb_rdata;
    logic                       sc_we, sc_re;
    logic [CNT_W-1:0]           sc_wdata, sc_rdata;
    logic                       dr_we, dr_re;
    logic [DIR_AW-1:0]          dr_addr;
    logic [1:0]                 dr_wdata, dr_rdata;
    logic                       rb_we, rb_re;
    logic [AW-1:0]              rb_waddr, rb_raddr;
    logic [lcs_pkg::SYM_W-1:0]  rb_rdata;

    assign im1     = i_reg - 1'b1;
    assign jm1     = j_reg - 1'b1;
    assign rev_idx = k_reg - 1'b1 - r_reg;
    assign dr_addr = DIR_AW'({im1[AW-1:0], jm1[AW-1:0]});

    lcs_ram #(.WIDTH(lcs_pkg::SYM_W), .DEPTH(MAX_LEN)) u_seq_a (
        .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(fe.symbol),
        .re(sa_re), .raddr(sa_raddr), .rdata(sa_rdata)
    );

    lcs_ram #(.WIDTH(lcs_pkg::SYM_W), .DEPTH(MAX_LEN)) u_seq_b (
        .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(fe.symbol),
        .re(sb_re), .raddr(jm1[AW-1:0]), .rdata(sb_rdata)
    );

    // Rolling score row, entry j-1 holds column j
    lcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_score (
        .clk(clk), .we(sc_we), .waddr(jm1[AW-1:0]), .wdata(sc_wdata),
        .re(sc_re), .raddr(jm1[AW-1:0]), .rdata(sc_rdata)
    );

    lcs_ram #(.WIDTH(2), .DEPTH(DIR_DEPTH)) u_dir (
        .clk(clk), .we(dr_we), .waddr(dr_addr), .wdata(dr_wdata),
        .re(dr_re), .raddr(dr_addr), .rdata(dr_rdata)
    );

    // Traceback symbols in reverse order
    lcs_ram #(.WIDTH(lcs_pkg::SYM_W), .DEPTH(MAX_LEN)) u_result (
        .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(sa_rdata),
        .re(rb_re), .raddr(rb_raddr), .rdata(rb_rdata)
    );

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_item_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !pop;
        out_item_next  = out_item_reg;
        take     = 1'b0;
        sa_we    = 1'b0;
        sa_re    = 1'b0;
        sa_waddr = count_a_reg[AW-1:0];
        sa_raddr = im1[AW-1:0];
        sb_we    = 1'b0;
        sb_re    = 1'b0;
        sb_waddr = count_b_reg[AW-1:0];
        sc_we    = 1'b0;
        sc_re    = 1'b0;
        sc_wdata = '0;
        dr_we    = 1'b0;
        dr_re    = 1'b0;
        dr_wdata = lcs_pkg::DIR_UP;
        rb_we    = 1'b0;
        rb_re    = 1'b0;
        rb_waddr = k_reg[AW-1:0];
        rb_raddr = rev_idx[AW-1:0];

        case (state_reg)
            lcs_pkg::ST_IDLE:
            begin
                if (fe.valid)
                begin
                    take = 1'b1;
                    case (fe.kind)
                        lcs_pkg::OP_LOAD_A:
                        begin
                            if (count_a_reg < MAX_CNT)
                            begin
                                sa_we        = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end
                        lcs_pkg::OP_LOAD_B:
                        begin
                            if (count_b_reg < MAX_CNT)
                            begin
                                sb_we        = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                        end
                        lcs_pkg::OP_RUN:
                        begin
                            m_next       = count_a_reg;
                            n_next       = count_b_reg;
                            i_next       = count_a_reg;
                            j_next       = count_b_reg;
                            k_next       = '0;
                            count_a_next = '0;
                            count_b_next = '0;
                            if (count_a_reg == '0 || count_b_reg == '0)
                            begin
                                state_next = lcs_pkg::ST_EMIT_SET;
                            end
                            else
                            begin
                                j_next     = CNT_W'(1);
                                state_next = lcs_pkg::ST_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Clear the score row, one column a cycle
            lcs_pkg::ST_INIT:
            begin
                sc_we    = 1'b1;
                sc_wdata = '0;
                if (j_reg == n_reg)
                begin
                    i_next     = CNT_W'(1);
                    state_next = lcs_pkg::ST_ROW;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            // Fetch the A symbol of this row; read data holds for the row
            lcs_pkg::ST_ROW:
            begin
                sa_re      = 1'b1;
                j_next     = CNT_W'(1);
                diag_next  = '0;
                left_next  = '0;
                state_next = lcs_pkg::ST_CELL_RD;
            end

            lcs_pkg::ST_CELL_RD:
            begin
                sb_re      = 1'b1;
                sc_re      = 1'b1;
                state_next = lcs_pkg::ST_CELL;
            end

            // One cell of the recurrence; ties go up
            lcs_pkg::ST_CELL:
            begin
                sc_we = 1'b1;
                dr_we = 1'b1;
                if (sa_rdata == sb_rdata)
                begin
                    sc_wdata = diag_reg + 1'b1;
                    dr_wdata = lcs_pkg::DIR_DIAG;
                end
                else if (sc_rdata >= left_reg)
                begin
                    sc_wdata = sc_rdata;
                    dr_wdata = lcs_pkg::DIR_UP;
                end
                else
                begin
                    sc_wdata = left_reg;
                    dr_wdata = lcs_pkg::DIR_LEFT;
                end
                diag_next = sc_rdata;
                left_next = sc_wdata;
                if (j_reg == n_reg)
                begin
                    if (i_reg == m_reg)
                    begin
                        state_next = lcs_pkg::ST_TB_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = lcs_pkg::ST_ROW;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = lcs_pkg::ST_CELL_RD;
                end
            end

            // Traceback from the far corner
            lcs_pkg::ST_TB_RD:
            begin
                if (i_reg == '0 || j_reg == '0)
                begin
                    state_next = lcs_pkg::ST_EMIT_SET;
                end
                else
                begin
                    dr_re      = 1'b1;
                    sa_re      = 1'b1;
                    state_next = lcs_pkg::ST_TB;
                end
            end

            lcs_pkg::ST_TB:
            begin
                state_next = lcs_pkg::ST_TB_RD;
                case (dr_rdata)
                    lcs_pkg::DIR_DIAG:
                    begin
                        rb_we  = 1'b1;
                        k_next = k_reg + 1'b1;
                        i_next = im1;
                        j_next = jm1;
                    end
                    lcs_pkg::DIR_UP:
                    begin
                        i_next = im1;
                    end
                    default:
                    begin
                        j_next = jm1;
                    end
                endcase
            end

            lcs_pkg::ST_EMIT_SET:
            begin
                r_next     = '0;
                state_next = (k_reg == '0) ? lcs_pkg::ST_EMPTY : lcs_pkg::ST_EM_RD;
            end

            // Nothing in common: a single empty result
            lcs_pkg::ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.out_symbol   = '0;
                    out_item_next.symbol_valid = 1'b0;
                    out_item_next.lcs_length   = '0;
                    out_item_next.last         = 1'b1;
                    state_next                 = lcs_pkg::ST_IDLE;
                end
            end

            lcs_pkg::ST_EM_RD:
            begin
                rb_re      = 1'b1;
                state_next = lcs_pkg::ST_EM;
            end

            // Forward order output; waits while the output register is held
            lcs_pkg::ST_EM:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.out_symbol   = rb_rdata;
                    out_item_next.symbol_valid = 1'b1;
                    out_item_next.lcs_length   = OUT_LW'(k_reg);
                    out_item_next.last         = (r_reg + 1'b1 == k_reg);
                    r_next                     = r_reg + 1'b1;
                    state_next = (r_reg + 1'b1 == k_reg) ? lcs_pkg::ST_IDLE
                                                         : lcs_pkg::ST_EM_RD;
                end
            end

            default:
            begin
                state_next = lcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcs_pkg::ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        r_reg        <= r_next;
        diag_reg     <= diag_next;
        left_reg     <= left_next;
        out_item_reg <= out_item_next;
    end

endmodule

// File: hdl/lcs_table_and_traceback_top.sv
// Top level of the LCS table and traceback block.
//
// Input queue: drive item with push; a transfer happens when push is high and
// full is low. cmd 0 and 1 append a symbol to sequence A or B (ignored once
// MAX_LEN are held), cmd 2 computes, cmd 3 is taken and dropped.
// Result queue: while empty is low the oldest result is on result; pop takes
// it. A compute gives one result per common symbol in forward order, last set
// on the final one, or a single result with symbol_valid low if none.
// Loads pass through a two-entry front queue and are taken while the engine
// is idle. A compute of m by n symbols clears the score row, then sweeps the
// table with one score RAM read and one write per cell, then traces back and
// emits the results in forward order.
// Both counts clear once a compute starts; later items wait in the queue.
// When the receiver stalls the output register holds its result and the
// engine waits, while the front queue keeps taking items until it fills.
// Reset empties both queues, clears the counts and leaves the engine idle;
// the RAMs need no clearing.
module lcs_table_and_traceback_top #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lcs_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output lcs_pkg::out_item_t result
);

    lcs_pkg::fe_to_be_t fe;
    logic               take;

    lcs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .take  (take),
        .fe    (fe)
    );

    lcs_engine #(.MAX_LEN(MAX_LEN)) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fe     (fe),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

// File: hdl/lcs_chk.sv
// Port-level assertions for the LCS block, bound to the top level.
`include "assert_macros.svh"

module lcs_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input lcs_pkg::out_item_t result
);

    logic                     mid_run_reg;
    logic [lcs_pkg::LEN_W-1:0] len_reg;

    // Track an open run of results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_run_reg <= 1'b0;
            len_reg     <= '0;
        end
        else if (pop && !empty)
        begin
            mid_run_reg <= !result.last;
            len_reg     <= result.lcs_length;
        end
    end

    // A held result does not change
    `ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(result))

    // An empty result stands alone and carries nothing
    `ASSERT_IMP(a_empty_form, clk, rst_n, !empty && !result.symbol_valid,
                result.last && result.lcs_length == '0 && result.out_symbol == '0)

    // Within a run every result holds a symbol and the same length
    `ASSERT_IMP(a_run_cont, clk, rst_n, !empty && mid_run_reg,
                result.symbol_valid && result.lcs_length == len_reg)

endmodule

bind lcs_table_and_traceback_top lcs_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// File: verif/lcs_table_and_traceback_top_test.sv
// Self-checking testbench for the LCS table and traceback block.
module lcs_table_and_traceback_top_test;
    import lcs_pkg::*;

    localparam int         SEQ_LEN       = MAX_LEN_DEF;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         SETTLE_CYCLES = 3000;
    localparam int         RANDOM_ITEMS  = 40;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_item_t  item  = '0;
    logic      empty;
    logic      pop   = 1'b0;
    out_item_t result;

    // Mirror of the block's sequence store
    logic [SEQ_LEN-1:0][7:0] mirror_a;
    logic [SEQ_LEN-1:0][7:0] mirror_b;
    int                      mirror_count_a = 0;
    int                      mirror_count_b = 0;

    // Subsequence symbols still owed by the block, oldest first
    out_item_t lcs_symbols_due[$];

    int error_count     = 0;
    int cycle_count     = 0;
    int effective_items = 0;
    int burst_left      = 0;
    int rx_mode         = 0;
    int rx_phase_left   = 0;

    lcs_table_and_traceback_top #(
        .MAX_LEN(SEQ_LEN)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    // Clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Score table sweep, tie goes up (drop the A symbol), then traceback
    task compute_common_subsequence;
        int         score [0:SEQ_LEN][0:SEQ_LEN];
        logic [1:0] step_dir [0:SEQ_LEN-1][0:SEQ_LEN-1];
        logic [7:0] common [$];
        int         i;
        int         j;
        out_item_t  res;
        common.delete();
        for (i = 0; i <= SEQ_LEN; i++)
            for (j = 0; j <= SEQ_LEN; j++)
                score[i][j] = 0;
        for (i = 1; i <= mirror_count_a; i++)
        begin
            for (j = 1; j <= mirror_count_b; j++)
            begin
                if (mirror_a[i-1] == mirror_b[j-1])
                begin
                    score[i][j]        = score[i-1][j-1] + 1;
                    step_dir[i-1][j-1] = DIR_DIAG;
                end
                else if (score[i-1][j] >= score[i][j-1])
                begin
                    score[i][j]        = score[i-1][j];
                    step_dir[i-1][j-1] = DIR_UP;
                end
                else
                begin
                    score[i][j]        = score[i][j-1];
                    step_dir[i-1][j-1] = DIR_LEFT;
                end
            end
        end
        i = mirror_count_a;
        j = mirror_count_b;
        while (i > 0 && j > 0)
        begin
            if (step_dir[i-1][j-1] == DIR_DIAG)
            begin
                common.push_front(mirror_a[i-1]);
                i--;
                j--;
            end
            else if (step_dir[i-1][j-1] == DIR_UP)
                i--;
            else
                j--;
        end
        if (common.size() == 0)
        begin
            res      = '0;
            res.last = 1'b1;
            lcs_symbols_due.push_back(res);
        end
        else
        begin
            for (i = 0; i < common.size(); i++)
            begin
                res.out_symbol   = common[i];
                res.symbol_valid = 1'b1;
                res.lcs_length   = LEN_W'(common.size());
                res.last         = (i == common.size() - 1);
                lcs_symbols_due.push_back(res);
            end
        end
        mirror_count_a = 0;
        mirror_count_b = 0;
    endtask

    // Apply one accepted item to the mirror
    task automatic absorb_item(input in_item_t it);
        case (it.cmd)
            CMD_LOAD_A:
                if (mirror_count_a < SEQ_LEN)
                begin
                    mirror_a[mirror_count_a] = it.symbol;
                    mirror_count_a++;
                    effective_items++;
                end
            CMD_LOAD_B:
                if (mirror_count_b < SEQ_LEN)
                begin
                    mirror_b[mirror_count_b] = it.symbol;
                    mirror_count_b++;
                    effective_items++;
                end
            CMD_RUN:
            begin
                compute_common_subsequence();
                effective_items++;
            end
            default: ;
        endcase
    endtask

    // One input transfer, with burst and gap pacing
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] sym);
        in_item_t it;
        int       gap;
        it.cmd    = cmd;
        it.symbol = sym;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full !== 1'b0);
        absorb_item(it);
    endtask

    // Hold the sender off until every owed result has come out
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (lcs_symbols_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_symbol(input int alphabet, input logic [7:0] base);
        if (alphabet == 0)
            return base + 8'($urandom_range(0, 3));
        else if (alphabet == 2)
            return base + 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: pop pattern changes mode at the end of each random-length phase
    always @(negedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(8, 80);
        end
        rx_phase_left--;
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (rx_phase_left % 5 == 0);
        endcase
    end

    // Result check against the oldest owed result
    always @(posedge clk)
    begin : check_results
        out_item_t due;
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
        begin
            if (lcs_symbols_due.size() == 0)
                report_mismatch($sformatf("result with none owed: %p", result));
            else
            begin
                due = lcs_symbols_due.pop_front();
                check_field("out_symbol", result.out_symbol, due.out_symbol);
                check_field("symbol_valid", 8'(result.symbol_valid), 8'(due.symbol_valid));
                check_field("lcs_length", 8'(result.lcs_length), 8'(due.lcs_length));
                check_field("last", 8'(result.last), 8'(due.last));
            end
        end
    end

    // Empty inputs: both empty straight after reset, A only, B only
    task automatic test_empty_inputs();
        send_item(CMD_RUN, 8'h00);
        send_item(CMD_LOAD_A, 8'h00);
        send_item(CMD_LOAD_A, 8'hFF);
        send_item(CMD_RUN, 8'hFF);
        send_item(CMD_LOAD_B, 8'hFF);
        send_item(CMD_RUN, 8'h5A);
    endtask

    // Matching rules: no common symbol, ties, unused command, extreme bytes
    task automatic test_match_rules();
        send_item(CMD_LOAD_A, 8'h12);
        send_item(CMD_UNUSED, 8'h34);
        send_item(CMD_LOAD_B, 8'h12);
        send_item(CMD_RUN, 8'hFF);
        send_item(CMD_LOAD_A, 8'h01);
        send_item(CMD_LOAD_A, 8'h02);
        send_item(CMD_LOAD_A, 8'h03);
        send_item(CMD_LOAD_B, 8'h04);
        send_item(CMD_LOAD_B, 8'h05);
        send_item(CMD_RUN, 8'h00);
        // tie: the upper cell wins, so the answer is the earlier A symbol
        send_item(CMD_LOAD_A, 8'h01);
        send_item(CMD_LOAD_A, 8'h02);
        send_item(CMD_LOAD_B, 8'h02);
        send_item(CMD_LOAD_B, 8'h01);
        send_item(CMD_RUN, 8'hAA);
        send_item(CMD_LOAD_A, 8'h00);
        send_item(CMD_LOAD_A, 8'hFF);
        send_item(CMD_LOAD_B, 8'hFF);
        send_item(CMD_LOAD_B, 8'h00);
        send_item(CMD_RUN, 8'h55);
    endtask

    // Full sequences with loads past the end, longest possible answer
    task automatic test_full_sequences();
        logic [7:0] shared [$];
        int         k;
        for (k = 0; k < SEQ_LEN + 2; k++)
            shared.push_back(8'($urandom_range(0, 255)));
        foreach (shared[k])
            send_item(CMD_LOAD_A, shared[k]);
        foreach (shared[k])
            send_item(CMD_LOAD_B, shared[k]);
        send_item(CMD_LOAD_B, 8'($urandom_range(0, 255)));
        send_item(CMD_RUN, 8'($urandom_range(0, 255)));
        for (k = 0; k < SEQ_LEN + 1; k++)
            send_item(CMD_LOAD_A, pick_symbol(0, 8'hC0));
        for (k = 0; k < SEQ_LEN + 3; k++)
            send_item(CMD_LOAD_B, pick_symbol(0, 8'hC0));
        send_item(CMD_RUN, 8'($urandom_range(0, 255)));
    endtask

    // Sender holds off until the block has emptied, mid-sequence as well
    task automatic test_pause_until_drained();
        int k;
        for (k = 0; k < 5; k++)
        begin
            send_item(CMD_LOAD_A, pick_symbol(0, 8'h40));
            send_item(CMD_LOAD_B, pick_symbol(0, 8'h40));
        end
        send_item(CMD_RUN, 8'h00);
        wait_drained();
        for (k = 0; k < 3; k++)
            send_item(CMD_LOAD_A, pick_symbol(0, 8'h7E));
        wait_drained();
        for (k = 0; k < 3; k++)
            send_item(CMD_LOAD_B, pick_symbol(0, 8'h7E));
        send_item(CMD_RUN, 8'h81);
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 8);
        else if (roll < 94)
            return $urandom_range(9, 20);
        return $urandom_range(24, 36);
    endfunction

    // Random well-formed sequences, with noise and the odd missing compute
    task automatic test_random_sequences();
        logic [7:0] a_syms [$];
        logic [7:0] b_syms [$];
        logic [7:0] base;
        int         alphabet;
        int         length_a;
        int         length_b;
        int         roll;
        int         k;
        int         start_items;
        start_items = effective_items;
        while (effective_items < start_items + RANDOM_ITEMS)
        begin
            a_syms.delete();
            b_syms.delete();
            alphabet = $urandom_range(0, 3);
            base     = 8'($urandom_range(0, 255));
            length_a = pick_length();
            length_b = pick_length();
            for (k = 0; k < length_a; k++)
                a_syms.push_back(pick_symbol(alphabet == 3 ? 2 : alphabet, base));
            if (alphabet == 3)
            begin
                // B as a mutated copy of A: drops, swaps and keeps
                foreach (a_syms[k])
                begin
                    roll = $urandom_range(0, 9);
                    if (roll >= 4)
                        b_syms.push_back(a_syms[k]);
                    else if (roll >= 2)
                        b_syms.push_back(pick_symbol(2, base));
                end
            end
            else
            begin
                for (k = 0; k < length_b; k++)
                    b_syms.push_back(pick_symbol(alphabet, base));
            end
            while (a_syms.size() + b_syms.size() != 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
                if (b_syms.size() == 0 || (a_syms.size() != 0 && $urandom_range(0, 1) == 1))
                    send_item(CMD_LOAD_A, a_syms.pop_front());
                else
                    send_item(CMD_LOAD_B, b_syms.pop_front());
            end
            if ($urandom_range(0, 9) != 0)
                send_item(CMD_RUN, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        send_item(CMD_RUN, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_inputs();
        test_match_rules();
        test_full_sequences();
        test_pause_until_drained();
        test_random_sequences();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && lcs_symbols_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
